// File: design/tdft_pkg.sv
// ----------------------------------------------------------------------------
// tdft_pkg: shared types and constants for the thrust direction pipeline
// Holds the pipeline control bundle, register indexes and fixed-point ones.
// ----------------------------------------------------------------------------
package tdft_pkg;

	// Control that every pipelined arithmetic unit receives from the top level.
	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

	typedef enum logic [1:0] {
		REG_AXIS_X     = 2'd0,
		REG_AXIS_Y     = 2'd1,
		REG_AXIS_Z     = 2'd2,
		REG_MAX_TORQUE = 2'd3
	} cfg_reg_t;

	localparam logic [15:0] ONE_Q14 = 16'd16384;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [61:0] ONE_Q60 = 62'h1000_0000_0000_0000;

	localparam logic signed [15:0] AXIS_X_RST     = 16'sd0;
	localparam logic signed [15:0] AXIS_Y_RST     = 16'sd0;
	localparam logic signed [15:0] AXIS_Z_RST     = 16'sd16384;
	localparam logic [30:0]        MAX_TORQUE_RST = 31'd65536;

endpackage

// File: design/tdft_isqrt.sv
// ----------------------------------------------------------------------------
// tdft_isqrt: pipelined integer square root
// Floor square root, one result bit per register stage, with a side payload
// that travels alongside.
// ----------------------------------------------------------------------------
module tdft_isqrt #(
	parameter int XW = 64,
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tdft_pkg::pipe_ctl_t ctl,
	input  logic [XW-1:0]       x,
	input  logic [SW-1:0]       side_in,
	output logic                vld,
	output logic [XW/2-1:0]     root,
	output logic [SW-1:0]       side_out
);
	localparam int RW = XW / 2;

	logic          vld_s  [RW+1];
	logic [XW-1:0] rem_s  [RW+1];
	logic [RW-1:0] root_s [RW+1];
	logic [SW-1:0] side_s [RW+1];

	assign vld_s[0]  = ctl.vld;
	assign rem_s[0]  = x;
	assign root_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < RW; k++) begin : g_stage
		localparam int I = RW - 1 - k;
		logic [XW:0] trial;
		logic        take;

		// Growing the root by 2^I adds root*2^(I+1) + 2^(2I) to its square.
		assign trial = ((XW+1)'(root_s[k]) << (I + 1)) + ((XW+1)'(1) << (2 * I));
		assign take  = {1'b0, rem_s[k]} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[k+1]  <= take ? XW'({1'b0, rem_s[k]} - trial) : rem_s[k];
				root_s[k+1] <= take ? (root_s[k] | (RW'(1) << I)) : root_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld      = vld_s[RW];
	assign root     = root_s[RW];
	assign side_out = side_s[RW];

endmodule

// File: design/tdft_udiv.sv
// ----------------------------------------------------------------------------
// tdft_udiv: pipelined unsigned restoring divider
// One quotient bit per register stage. The caller guarantees that the
// quotient fits in QW bits; the remainder is dropped.
// ----------------------------------------------------------------------------
module tdft_udiv #(
	parameter int NW = 61,
	parameter int DW = 32,
	parameter int QW = 31,
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tdft_pkg::pipe_ctl_t ctl,
	input  logic [NW-1:0]       num,
	input  logic [DW-1:0]       den,
	input  logic [SW-1:0]       side_in,
	output logic                vld,
	output logic [QW-1:0]       quot,
	output logic [SW-1:0]       side_out
);
	localparam int WW = (NW > DW + QW) ? NW : DW + QW;

	logic          vld_s  [QW+1];
	logic [NW-1:0] rem_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [QW-1:0] quot_s [QW+1];
	logic [SW-1:0] side_s [QW+1];

	assign vld_s[0]  = ctl.vld;
	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quot_s[0] = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int I = QW - 1 - k;
		logic [WW-1:0] trial;
		logic          take;

		assign trial = WW'(den_s[k]) << I;
		assign take  = WW'(rem_s[k]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ctl.en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				rem_s[k+1]  <= take ? NW'(WW'(rem_s[k]) - trial) : rem_s[k];
				quot_s[k+1] <= take ? (quot_s[k] | (QW'(1) << I)) : quot_s[k];
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign vld      = vld_s[QW];
	assign quot     = quot_s[QW];
	assign side_out = side_s[QW];

endmodule

// File: design/thrust_direction_from_torque_top.sv
// Pipeline: 157 register stages; three square-root chains and two divider
// chains of one bit per stage make up most of them.
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// Reset: arst_n clears every valid bit and loads the register reset values.
// ----------------------------------------------------------------------------
// thrust_direction_from_torque_top: thrust direction from requested torque
// Crosses the torque with the moment-arm axis, blends the unit of that with
// the negative axis by the torque fraction, renormalizes and saturates.
// ----------------------------------------------------------------------------
module thrust_direction_from_torque_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] torque_x,
	input  logic signed [31:0] torque_y,
	input  logic signed [31:0] torque_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y,
	output logic signed [15:0] dir_z
);
	typedef struct packed {
		logic             nz;
		logic [4:0]       sh;
		logic [2:0]       neg;
		logic [2:0][30:0] q;
	} n_side_t;

	typedef struct packed {
		logic [30:0]      m;
		logic [2:0][31:0] u;
	} a_side_t;

	typedef struct packed {
		logic [2:0]       sv;
		logic [2:0][29:0] vm;
	} w_side_t;

	logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;
	logic [30:0]        mt_q;
	logic signed [15:0] axis_c [3];

	logic en;
	tdft_pkg::pipe_ctl_t ctl_n, ctl_d, ctl_a, ctl_w, ctl_o;

	// Front end: cross product, normalizing shift, squares.
	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [47:0] pr_s1 [6];
	logic signed [48:0] p_s2 [3];
	logic [47:0]        mag_c [3];
	logic [47:0]        mx_c;
	logic [47:0]        mag_s3 [3];
	logic [2:0]         neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [47:0]        mx_s3;
	logic [4:0]         sh_c;
	logic [47:0]        mag_s4 [3];
	logic [4:0]         sh_s4, sh_s5, sh_s6, sh_s7;
	logic               nz_s4, nz_s5, nz_s6, nz_s7;
	logic [30:0]        q_s5 [3];
	logic [30:0]        q_s6 [3];
	logic [30:0]        q_s7 [3];
	logic [61:0]        sq_s6 [3];
	logic [63:0]        sum_s7;
	n_side_t            n_side_in, n_side;
	logic               n_vld;
	logic [31:0]        n_root;

	// Torque fraction and unit of p.
	logic               v_s40;
	logic [48:0]        len_c;
	logic               sat_c;
	logic [60:0]        numu_s40 [3];
	logic [60:0]        numm_s40;
	logic [31:0]        n_s40;
	logic               sat_s40, nz_s40;
	logic [2:0]         neg_s40;
	logic [2:0]         du_vld;
	logic [30:0]        du_q [3];
	logic [2:0]         du_neg;
	logic               dm_vld;
	logic [30:0]        dm_q;
	logic [1:0]         dm_side;

	logic               v_s72, v_s73, v_s74;
	logic signed [31:0] u_s72 [3];
	logic signed [31:0] u_s73 [3];
	logic signed [31:0] u_s74 [3];
	logic [30:0]        m_s72, m_s73, m_s74;
	logic [60:0]        msq_s73;
	logic [61:0]        x_s74;
	a_side_t            a_side_in, a_side;
	logic               a_vld;
	logic [30:0]        a_root;

	// Blend, renormalize.
	logic               v_s106, v_s107, v_s108, v_s109;
	logic [30:0]        umag_c [3];
	logic [15:0]        axmag_c [3];
	logic [60:0]        pmu_s106 [3];
	logic [46:0]        pa_s106 [3];
	logic [2:0]         su_s106, sa_s106;
	logic signed [31:0] v_c [3];
	logic signed [31:0] v_s107_q [3];
	logic [29:0]        vm_c [3];
	logic [29:0]        vm_s108 [3];
	logic [29:0]        vm_s109 [3];
	logic [59:0]        vsq_s108 [3];
	logic [2:0]         sv_s108, sv_s109;
	logic [61:0]        vsum_s109;
	w_side_t            w_side_in, w_side;
	logic               w_vld;
	logic [30:0]        w_root;

	logic               v_s141;
	logic [43:0]        numd_s141 [3];
	logic [30:0]        w_s141;
	logic               wz_s141;
	logic [2:0]         sv_s141;
	logic [2:0]         dd_vld;
	logic [14:0]        dd_q [3];
	logic [1:0]         dd_side [3];

	logic               v_s157;
	logic signed [15:0] dir_c [3];
	logic signed [15:0] dir_s157 [3];

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q <= tdft_pkg::AXIS_X_RST;
			axis_y_q <= tdft_pkg::AXIS_Y_RST;
			axis_z_q <= tdft_pkg::AXIS_Z_RST;
			mt_q     <= tdft_pkg::MAX_TORQUE_RST;
		end else if (cfg_we) begin
			unique case (tdft_pkg::cfg_reg_t'(cfg_index))
				tdft_pkg::REG_AXIS_X:     axis_x_q <= cfg_data[15:0];
				tdft_pkg::REG_AXIS_Y:     axis_y_q <= cfg_data[15:0];
				tdft_pkg::REG_AXIS_Z:     axis_z_q <= cfg_data[15:0];
				tdft_pkg::REG_MAX_TORQUE: mt_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign axis_c[0] = axis_x_q;
	assign axis_c[1] = axis_y_q;
	assign axis_c[2] = axis_z_q;

	// The whole pipeline moves together; it holds only while a result waits.
	assign en        = !v_s157 || out_ready;
	assign in_ready  = en;
	assign out_valid = v_s157;

	// ------------------------------------------------------------------
	// Valid bits of the stages in this module
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
			v_s40  <= 1'b0;
			v_s72  <= 1'b0;
			v_s73  <= 1'b0;
			v_s74  <= 1'b0;
			v_s106 <= 1'b0;
			v_s107 <= 1'b0;
			v_s108 <= 1'b0;
			v_s109 <= 1'b0;
			v_s141 <= 1'b0;
			v_s157 <= 1'b0;
		end else if (en) begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
			v_s7   <= v_s6;
			v_s40  <= n_vld;
			v_s72  <= dm_vld & (&du_vld);
			v_s73  <= v_s72;
			v_s74  <= v_s73;
			v_s106 <= a_vld;
			v_s107 <= v_s106;
			v_s108 <= v_s107;
			v_s109 <= v_s108;
			v_s141 <= w_vld;
			v_s157 <= &dd_vld;
		end
	end

	// ------------------------------------------------------------------
	// Stages 1 to 7: p = torque x axis, shift into 31 bits, sum of squares
	// ------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = p_s2[i][48] ? 48'(-p_s2[i]) : 48'(p_s2[i]);
		end
		mx_c = mag_c[0];
		if (mag_c[1] > mx_c) mx_c = mag_c[1];
		if (mag_c[2] > mx_c) mx_c = mag_c[2];
	end

	// Smallest shift that brings the largest magnitude below 2^31.
	always_comb begin
		sh_c = '0;
		for (int b = 31; b < 48; b++) begin
			if (mx_s3[b]) sh_c = 5'(b - 30);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s1[0] <= torque_y * axis_z_q;
			pr_s1[1] <= torque_z * axis_y_q;
			pr_s1[2] <= torque_z * axis_x_q;
			pr_s1[3] <= torque_x * axis_z_q;
			pr_s1[4] <= torque_x * axis_y_q;
			pr_s1[5] <= torque_y * axis_x_q;

			for (int i = 0; i < 3; i++) begin
				p_s2[i] <= 49'(pr_s1[2*i]) - 49'(pr_s1[2*i+1]);
			end

			for (int i = 0; i < 3; i++) begin
				mag_s3[i] <= mag_c[i];
				neg_s3[i] <= p_s2[i][48];
			end
			mx_s3 <= mx_c;

			mag_s4 <= mag_s3;
			neg_s4 <= neg_s3;
			sh_s4  <= sh_c;
			nz_s4  <= mx_s3 != '0;

			for (int i = 0; i < 3; i++) begin
				q_s5[i] <= 31'(mag_s4[i] >> sh_s4);
			end
			neg_s5 <= neg_s4;
			sh_s5  <= sh_s4;
			nz_s5  <= nz_s4;

			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= q_s5[i] * q_s5[i];
			end
			q_s6   <= q_s5;
			neg_s6 <= neg_s5;
			sh_s6  <= sh_s5;
			nz_s6  <= nz_s5;

			sum_s7 <= 64'(sq_s6[0]) + 64'(sq_s6[1]) + 64'(sq_s6[2]);
			q_s7   <= q_s6;
			neg_s7 <= neg_s6;
			sh_s7  <= sh_s6;
			nz_s7  <= nz_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stages 8 to 39: n = floor(sqrt(sum))
	// ------------------------------------------------------------------
	assign ctl_n = '{en: en, vld: v_s7};

	always_comb begin
		n_side_in.nz  = nz_s7;
		n_side_in.sh  = sh_s7;
		n_side_in.neg = neg_s7;
		for (int i = 0; i < 3; i++) begin
			n_side_in.q[i] = q_s7[i];
		end
	end

	tdft_isqrt #(
		.XW (64),
		.SW ($bits(n_side_t))
	) u_sqrt_n (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_n),
		.x        (sum_s7),
		.side_in  (n_side_in),
		.vld      (n_vld),
		.root     (n_root),
		.side_out (n_side)
	);

	// ------------------------------------------------------------------
	// Stage 40: length of p against the torque limit, divider operands
	// ------------------------------------------------------------------
	assign len_c = 49'(n_root) << n_side.sh;
	assign sat_c = len_c >= {4'b0, mt_q, 14'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				numu_s40[i] <= {n_side.q[i], 30'b0};
			end
			// Under the limit the length is below 2^45, so the shift loses nothing.
			numm_s40 <= sat_c ? '0 : (61'(len_c) << 16);
			n_s40    <= n_root;
			sat_s40  <= sat_c;
			nz_s40   <= n_side.nz;
			neg_s40  <= n_side.neg;
		end
	end

	// ------------------------------------------------------------------
	// Stages 41 to 71: u = q * 2^30 / n and m = len * 2^16 / max_torque
	// ------------------------------------------------------------------
	assign ctl_d = '{en: en, vld: v_s40};

	for (genvar i = 0; i < 3; i++) begin : g_udiv
		tdft_udiv #(
			.NW (61),
			.DW (32),
			.QW (31),
			.SW (1)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_d),
			.num      (numu_s40[i]),
			.den      (n_s40),
			.side_in  (neg_s40[i]),
			.vld      (du_vld[i]),
			.quot     (du_q[i]),
			.side_out (du_neg[i])
		);
	end

	tdft_udiv #(
		.NW (61),
		.DW (31),
		.QW (31),
		.SW (2)
	) u_div_m (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_d),
		.num      (numm_s40),
		.den      (mt_q),
		.side_in  ({nz_s40, sat_s40}),
		.vld      (dm_vld),
		.quot     (dm_q),
		.side_out (dm_side)
	);

	// ------------------------------------------------------------------
	// Stages 72 to 74: signed u, m, and 1 - m^2 in Q60
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (!dm_side[1]) begin
					u_s72[i] <= '0;
				end else if (du_neg[i]) begin
					u_s72[i] <= -$signed(32'(du_q[i]));
				end else begin
					u_s72[i] <= $signed(32'(du_q[i]));
				end
			end
			if (!dm_side[1]) begin
				m_s72 <= '0;
			end else if (dm_side[0]) begin
				m_s72 <= tdft_pkg::ONE_Q30;
			end else begin
				m_s72 <= dm_q;
			end

			msq_s73 <= m_s72 * m_s72;
			m_s73   <= m_s72;
			u_s73   <= u_s72;

			x_s74 <= tdft_pkg::ONE_Q60 - 62'(msq_s73);
			m_s74 <= m_s73;
			u_s74 <= u_s73;
		end
	end

	// ------------------------------------------------------------------
	// Stages 75 to 105: a = floor(sqrt(2^60 - m^2))
	// ------------------------------------------------------------------
	assign ctl_a = '{en: en, vld: v_s74};

	always_comb begin
		a_side_in.m = m_s74;
		for (int i = 0; i < 3; i++) begin
			a_side_in.u[i] = u_s74[i];
		end
	end

	tdft_isqrt #(
		.XW (62),
		.SW ($bits(a_side_t))
	) u_sqrt_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_a),
		.x        (x_s74),
		.side_in  (a_side_in),
		.vld      (a_vld),
		.root     (a_root),
		.side_out (a_side)
	);

	// ------------------------------------------------------------------
	// Stages 106 to 109: v = m*u/2^32 - a*axis/2^16, sum of squares
	// ------------------------------------------------------------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			umag_c[i]  = a_side.u[i][31] ? 31'(-$signed(a_side.u[i])) : 31'(a_side.u[i]);
			axmag_c[i] = axis_c[i][15] ? 16'(-axis_c[i]) : 16'(axis_c[i]);
		end
	end

	// Both quotients truncate toward zero, so work on magnitudes.
	always_comb begin
		logic signed [31:0] t1, t2;
		for (int i = 0; i < 3; i++) begin
			t1 = $signed(32'(pmu_s106[i] >> 32));
			t2 = $signed(32'(pa_s106[i] >> 16));
			if (su_s106[i]) t1 = -t1;
			if (sa_s106[i]) t2 = -t2;
			v_c[i] = t1 - t2;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vm_c[i] = v_s107_q[i][31] ? 30'(-v_s107_q[i]) : 30'(v_s107_q[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pmu_s106[i] <= a_side.m * umag_c[i];
				pa_s106[i]  <= a_root * axmag_c[i];
				su_s106[i]  <= a_side.u[i][31];
				sa_s106[i]  <= axis_c[i][15];
			end

			v_s107_q <= v_c;

			for (int i = 0; i < 3; i++) begin
				vm_s108[i]  <= vm_c[i];
				vsq_s108[i] <= vm_c[i] * vm_c[i];
				sv_s108[i]  <= v_s107_q[i][31];
			end

			vsum_s109 <= 62'(vsq_s108[0]) + 62'(vsq_s108[1]) + 62'(vsq_s108[2]);
			vm_s109   <= vm_s108;
			sv_s109   <= sv_s108;
		end
	end

	// ------------------------------------------------------------------
	// Stages 110 to 140: w = floor(sqrt(sum v^2))
	// ------------------------------------------------------------------
	assign ctl_w = '{en: en, vld: v_s109};

	always_comb begin
		w_side_in.sv = sv_s109;
		for (int i = 0; i < 3; i++) begin
			w_side_in.vm[i] = vm_s109[i];
		end
	end

	tdft_isqrt #(
		.XW (62),
		.SW ($bits(w_side_t))
	) u_sqrt_w (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl_w),
		.x        (vsum_s109),
		.side_in  (w_side_in),
		.vld      (w_vld),
		.root     (w_root),
		.side_out (w_side)
	);

	// ------------------------------------------------------------------
	// Stage 141 and stages 142 to 156: dir = v * 2^14 / w
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				numd_s141[i] <= {w_side.vm[i], 14'b0};
			end
			w_s141  <= w_root;
			wz_s141 <= w_root == '0;
			sv_s141 <= w_side.sv;
		end
	end

	assign ctl_o = '{en: en, vld: v_s141};

	for (genvar i = 0; i < 3; i++) begin : g_ddiv
		tdft_udiv #(
			.NW (44),
			.DW (31),
			.QW (15),
			.SW (2)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl_o),
			.num      (numd_s141[i]),
			.den      (w_s141),
			.side_in  ({sv_s141[i], wz_s141}),
			.vld      (dd_vld[i]),
			.quot     (dd_q[i]),
			.side_out (dd_side[i])
		);
	end

	// ------------------------------------------------------------------
	// Stage 157: saturate and hold the result word
	// ------------------------------------------------------------------
	always_comb begin
		logic [15:0] qm;
		for (int i = 0; i < 3; i++) begin
			qm = (16'(dd_q[i]) > tdft_pkg::ONE_Q14) ? tdft_pkg::ONE_Q14 : 16'(dd_q[i]);
			if (dd_side[i][0]) begin
				dir_c[i] = '0;
			end else if (dd_side[i][1]) begin
				dir_c[i] = -$signed(qm);
			end else begin
				dir_c[i] = $signed(qm);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_s157 <= dir_c;
		end
	end

	assign dir_x = dir_s157[0];
	assign dir_y = dir_s157[1];
	assign dir_z = dir_s157[2];

`ifndef SYNTHESIS
	// A nonzero shift must leave at least one component with its top bit set.
	a_norm_shift: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && (sh_s5 != '0) |-> (q_s5[0][30] || q_s5[1][30] || q_s5[2][30]))
		else $error("normalizing shift too large");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s72 |-> (m_s72 <= tdft_pkg::ONE_Q30))
		else $error("torque fraction above one");

	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(du_vld == {3{dm_vld}}) && (dd_vld == {3{dd_vld[0]}}))
		else $error("parallel dividers out of step");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((dir_x <= 16'sd16384) && (dir_x >= -16'sd16384)
			&& (dir_y <= 16'sd16384) && (dir_y >= -16'sd16384)
			&& (dir_z <= 16'sd16384) && (dir_z >= -16'sd16384)))
		else $error("direction component outside unit range");
`endif

endmodule
